// ----- rtl/rscb_pkg.sv -----
// ----------------------------------------------------------------------------
// Rolling-sum chunk boundary package
// Shared constants, codes and types for the chunk boundary detector.
// ----------------------------------------------------------------------------
package rscb_pkg;

   // Depth of the window ring store and derived widths.
   localparam int MAX_SPAN = 1024;
   localparam int ADDR_W   = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
   localparam int EFF_W    = $clog2(MAX_SPAN + 1);

   // Field and register widths.
   localparam int SPAN_W  = 11;
   localparam int MOD_W   = 16;
   localparam int DIST_W  = 16;
   localparam int SUM_W   = 18;
   localparam int BYTE_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // The remainder unit retires one dividend bit per step.
   localparam int DIV_STEPS = SUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Transaction opcodes.
   localparam logic OP_DATA    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SPAN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUM_MODULUS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DISTANCE = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [SPAN_W-1:0] WINDOW_SPAN_RESET  = 11'd256;
   localparam logic [MOD_W-1:0]  SUM_MODULUS_RESET  = 16'd8192;
   localparam logic [DIST_W-1:0] MIN_DISTANCE_RESET = 16'd8192;

   // Status returned by the remainder unit.
   typedef struct packed {
      logic done;      // one-cycle pulse when the remainder is final
      logic rem_zero;  // dividend is a multiple of the divisor
   } div_status_type;

endpackage

// ----- rtl/rscb_remainder.sv -----
// ----------------------------------------------------------------------------
// Rolling-sum remainder unit
// Restoring bit-serial remainder of the window sum against the modulus,
// one dividend bit per cycle, reporting whether the remainder is zero.
// ----------------------------------------------------------------------------
module rscb_remainder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [rscb_pkg::SUM_W-1:0]         dividend,
   input  logic [rscb_pkg::MOD_W-1:0]         divisor,
   output rscb_pkg::div_status_type           status
);

   logic                              busy_ff, busy_in;
   logic [rscb_pkg::DIV_CNT_W-1:0]    count_ff, count_in;
   logic [rscb_pkg::SUM_W-1:0]        shift_ff, shift_in;
   logic [rscb_pkg::MOD_W-1:0]        divisor_ff, divisor_in;
   logic [rscb_pkg::MOD_W-1:0]        rem_ff, rem_in;
   logic                              sum_zero_ff, sum_zero_in;
   logic                              done_ff, done_in;
   logic                              zero_ff, zero_in;
   logic [rscb_pkg::MOD_W:0]          trial;
   logic [rscb_pkg::MOD_W-1:0]        rem_step;
   logic                              last_step;

   // One restoring step: shift in the next dividend bit and subtract if it fits.
   always_comb begin
      trial     = {rem_ff, shift_ff[rscb_pkg::SUM_W-1]};
      rem_step  = trial[rscb_pkg::MOD_W-1:0];
      if (trial >= {1'b0, divisor_ff}) begin
         rem_step = rscb_pkg::MOD_W'(trial - {1'b0, divisor_ff});
      end
      last_step = (count_ff == rscb_pkg::DIV_CNT_W'(rscb_pkg::DIV_STEPS - 1));
   end

   always_comb begin
      busy_in     = busy_ff;
      count_in    = count_ff;
      shift_in    = shift_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      sum_zero_in = sum_zero_ff;
      done_in     = 1'b0;
      zero_in     = zero_ff;
      if (start) begin
         busy_in     = 1'b1;
         count_in    = '0;
         shift_in    = dividend;
         divisor_in  = divisor;
         rem_in      = '0;
         sum_zero_in = (dividend == '0);
      end else if (busy_ff) begin
         rem_in   = rem_step;
         shift_in = {shift_ff[rscb_pkg::SUM_W-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            // A zero modulus leaves the sum itself as the remainder.
            zero_in = (divisor_ff == '0) ? sum_zero_ff : (rem_step == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      shift_ff    <= shift_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      sum_zero_ff <= sum_zero_in;
      zero_ff     <= zero_in;
   end

   assign status.done     = done_ff;
   assign status.rem_zero = zero_ff;

endmodule

// ----- rtl/rolling_sum_chunk_boundary.sv -----
// ----------------------------------------------------------------------------
// Rolling-sum chunk boundary detector
// A data transaction steps through the sequencer states in order: read the
// leaving byte from the window ring memory; update the sum, counters and
// ring and start the bit-serial remainder unit; wait for that unit (one
// sum bit per cycle plus its status register); load the result register;
// return to idle, where the next transaction is accepted. A restart
// transaction goes from idle straight to the result state. The result
// sits in its own register, so a new transaction is accepted while an
// earlier result is still stalled; a finished result that finds that
// register still stalled holds the sequencer in its result state until
// the register frees up. The ring memory needs no clearing pass after
// reset: a byte read back from it only enters the sum once the window
// has filled.
// ----------------------------------------------------------------------------
module rolling_sum_chunk_boundary (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input transactions.
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_opcode,
   input  logic [rscb_pkg::BYTE_W-1:0]           req_byte_value,
   // Result transactions.
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_boundary,
   // Configuration writes.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rscb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rscb_pkg::CSR_DATA_W-1:0]       csr_data
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_DIVIDE = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   logic [2:0]                        state_ff, state_in;

   // Configuration registers.
   logic [rscb_pkg::SPAN_W-1:0]       window_span_ff, window_span_in;
   logic [rscb_pkg::MOD_W-1:0]        sum_modulus_ff, sum_modulus_in;
   logic [rscb_pkg::DIST_W-1:0]       min_distance_ff, min_distance_in;

   // Running chunk state.
   logic [rscb_pkg::ADDR_W-1:0]       write_pos_ff, write_pos_in;
   logic [rscb_pkg::SUM_W-1:0]        window_sum_ff, window_sum_in;
   logic                              window_full_ff, window_full_in;
   logic [rscb_pkg::DIST_W-1:0]       bytes_seen_ff, bytes_seen_in;
   logic                              enabled_ff, enabled_in;

   // Transaction payload and results.
   logic [rscb_pkg::BYTE_W-1:0]       byte_ff, byte_in;
   logic [rscb_pkg::BYTE_W-1:0]       old_byte_ff;
   logic                              hit_ff, hit_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_boundary_ff, rsp_boundary_in;

   // Window ring memory.
   logic [rscb_pkg::BYTE_W-1:0]       ring_mem [rscb_pkg::MAX_SPAN];

   logic [rscb_pkg::EFF_W-1:0]        eff_span;
   logic [rscb_pkg::EFF_W-1:0]        next_pos;
   logic                              req_accept;
   logic                              csr_write;
   logic                              rsp_free;
   logic                              div_start;
   rscb_pkg::div_status_type          div_status;

   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_valid && csr_ready;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign div_start  = (state_ff == ST_UPDATE);

   // The sequencer owns the datapath, so only an idle block takes a transaction.
   assign req_stall    = (state_ff != ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_boundary = rsp_boundary_ff;

   // A span of zero acts as one, and a span beyond the ring acts as the full ring.
   always_comb begin
      if (window_span_ff == '0) begin
         eff_span = rscb_pkg::EFF_W'(1);
      end else if (32'(window_span_ff) > rscb_pkg::MAX_SPAN) begin
         eff_span = rscb_pkg::EFF_W'(rscb_pkg::MAX_SPAN);
      end else begin
         eff_span = rscb_pkg::EFF_W'(window_span_ff);
      end
      next_pos = rscb_pkg::EFF_W'(write_pos_ff) + 1'b1;
   end

   // Configuration writes; indexes past the register list are dropped.
   always_comb begin
      window_span_in  = window_span_ff;
      sum_modulus_in  = sum_modulus_ff;
      min_distance_in = min_distance_ff;
      if (csr_write) begin
         case (csr_index)
            rscb_pkg::CSR_WINDOW_SPAN: begin
               window_span_in = csr_data[rscb_pkg::SPAN_W-1:0];
            end
            rscb_pkg::CSR_SUM_MODULUS: begin
               sum_modulus_in = csr_data[rscb_pkg::MOD_W-1:0];
            end
            rscb_pkg::CSR_MIN_DISTANCE: begin
               min_distance_in = csr_data[rscb_pkg::DIST_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer and running state.
   always_comb begin
      state_in       = state_ff;
      write_pos_in   = write_pos_ff;
      window_sum_in  = window_sum_ff;
      window_full_in = window_full_ff;
      bytes_seen_in  = bytes_seen_ff;
      enabled_in     = enabled_ff;
      byte_in        = byte_ff;
      hit_in         = hit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               byte_in = req_byte_value;
               if (req_opcode == rscb_pkg::OP_RESTART) begin
                  // Restart clears the running state; the ring keeps its bytes.
                  write_pos_in   = '0;
                  window_sum_in  = '0;
                  window_full_in = 1'b0;
                  bytes_seen_in  = '0;
                  enabled_in     = 1'b0;
                  hit_in         = 1'b0;
                  state_in       = ST_RESULT;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // The leaving byte is fetched from the ring during this cycle.
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // Add the arriving byte and, once the ring has wrapped, drop the oldest.
            window_sum_in = window_sum_ff + rscb_pkg::SUM_W'(byte_ff)
                          - (window_full_ff ? rscb_pkg::SUM_W'(old_byte_ff)
                                            : rscb_pkg::SUM_W'(0));
            if (next_pos >= eff_span) begin
               write_pos_in   = '0;
               window_full_in = 1'b1;
            end else begin
               write_pos_in = rscb_pkg::ADDR_W'(next_pos);
            end
            // The enable compares the count before its saturating increment.
            if (bytes_seen_ff == min_distance_ff) begin
               enabled_in = 1'b1;
            end
            if (bytes_seen_ff != '1) begin
               bytes_seen_in = bytes_seen_ff + 1'b1;
            end
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               hit_in   = enabled_ff && div_status.rem_zero;
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register: loads when the finished result can move out.
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_boundary_in = rsp_boundary_ff;
      if ((state_ff == ST_RESULT) && rsp_free) begin
         rsp_valid_in    = 1'b1;
         rsp_boundary_in = hit_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         window_span_ff  <= rscb_pkg::WINDOW_SPAN_RESET;
         sum_modulus_ff  <= rscb_pkg::SUM_MODULUS_RESET;
         min_distance_ff <= rscb_pkg::MIN_DISTANCE_RESET;
         write_pos_ff    <= '0;
         window_sum_ff   <= '0;
         window_full_ff  <= 1'b0;
         bytes_seen_ff   <= '0;
         enabled_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         window_span_ff  <= window_span_in;
         sum_modulus_ff  <= sum_modulus_in;
         min_distance_ff <= min_distance_in;
         write_pos_ff    <= write_pos_in;
         window_sum_ff   <= window_sum_in;
         window_full_ff  <= window_full_in;
         bytes_seen_ff   <= bytes_seen_in;
         enabled_ff      <= enabled_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff         <= byte_in;
      hit_ff          <= hit_in;
      rsp_boundary_ff <= rsp_boundary_in;
   end

   // Ring memory: registered read of the leaving byte, then the write of the
   // arriving byte to the same slot in the following cycle.
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         old_byte_ff <= ring_mem[write_pos_ff];
      end
      if (state_ff == ST_UPDATE) begin
         ring_mem[write_pos_ff] <= byte_ff;
      end
   end

   // Remainder unit: window sum against the configured modulus.
   rscb_remainder u_remainder (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (window_sum_in),
      .divisor  (sum_modulus_ff),
      .status   (div_status)
   );

`ifndef NO_ASSERTIONS
   // A result only appears after the sequencer reached its result state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_RESULT))
      else $error("result raised outside the result state");

   // The remainder unit only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIVIDE))
      else $error("remainder finished while not awaited");

   // A restart leaves the running state cleared.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_opcode == rscb_pkg::OP_RESTART)) |=>
         ((window_sum_ff == '0) && (write_pos_ff == '0) && !enabled_ff
          && !window_full_ff && (bytes_seen_ff == '0)))
      else $error("restart did not clear running state");

   // A restart always reports no boundary.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_opcode == rscb_pkg::OP_RESTART)) |=> !hit_ff)
      else $error("restart produced a boundary");
`endif

endmodule

// ----- tb/rolling_sum_chunk_boundary_tb.sv -----
// ----------------------------------------------------------------------------
// Rolling-sum chunk boundary detector testbench
// Drives data and restart transactions through the detector under several
// register settings and checks every boundary flag against a cycle-free
// predictor. The predictor keeps its own window ring, sum, counter and enable.
// ----------------------------------------------------------------------------
module rolling_sum_chunk_boundary_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Register index that the block must ignore.
   localparam logic [rscb_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // Number of random transactions in the main stimulus part.
   localparam int RANDOM_ITEMS = 300;
   // Data transactions in the closing run over a mid-sized window.
   localparam int LONG_RUN_ITEMS = 80;
   // Cycles to wait after the last result before the block counts as idle.
   localparam int SETTLE_CYCLES = 30;
   // Cycles without any accepted transaction before the run is abandoned.
   localparam int QUIET_LIMIT = 4000;

   // -------------------------------------------------------------------------
   // Boundary predictor and result checker. It mirrors the detector state:
   // the registers, the ring of recent bytes, the rolling sum, the byte
   // counter and the sticky enable. Each accepted input transaction queues
   // one expected boundary flag; each accepted result pops the oldest one.
   // -------------------------------------------------------------------------
   class chunk_scoreboard;
      logic [rscb_pkg::SPAN_W-1:0] span_reg;
      logic [rscb_pkg::MOD_W-1:0]  mod_reg;
      logic [rscb_pkg::DIST_W-1:0] dist_reg;

      bit [rscb_pkg::BYTE_W-1:0]   ring [rscb_pkg::MAX_SPAN];
      int unsigned                 wr_pos;
      logic [rscb_pkg::SUM_W-1:0]  win_sum;
      bit                          full;
      logic [rscb_pkg::DIST_W-1:0] seen;
      bit                          armed;

      bit expected_boundary [$];
      int errors;
      int data_bytes;
      int restarts;
      int boundaries;

      function new();
         span_reg = rscb_pkg::WINDOW_SPAN_RESET;
         mod_reg  = rscb_pkg::SUM_MODULUS_RESET;
         dist_reg = rscb_pkg::MIN_DISTANCE_RESET;
         foreach (ring[i]) ring[i] = '0;
         clear_running();
      endfunction

      function void clear_running();
         wr_pos  = 0;
         win_sum = '0;
         full    = 1'b0;
         seen    = '0;
         armed   = 1'b0;
      endfunction

      // Span register zero behaves as one byte, anything past the ring
      // depth behaves as the full ring.
      function int unsigned eff_span(logic [rscb_pkg::SPAN_W-1:0] s);
         if (s == 0) return 1;
         if (s > rscb_pkg::MAX_SPAN) return rscb_pkg::MAX_SPAN;
         return s;
      endfunction

      function void apply_reg(logic [rscb_pkg::CSR_IDX_W-1:0] idx,
                              logic [rscb_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            rscb_pkg::CSR_WINDOW_SPAN:  span_reg = value[rscb_pkg::SPAN_W-1:0];
            rscb_pkg::CSR_SUM_MODULUS:  mod_reg  = value[rscb_pkg::MOD_W-1:0];
            rscb_pkg::CSR_MIN_DISTANCE: dist_reg = value[rscb_pkg::DIST_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_input(logic op, logic [rscb_pkg::BYTE_W-1:0] value);
         int unsigned                span;
         logic [rscb_pkg::SUM_W-1:0] rem;
         if (op == rscb_pkg::OP_RESTART) begin
            clear_running();
            restarts++;
            expected_boundary.push_back(1'b0);
            return;
         end
         data_bytes++;
         span = eff_span(span_reg);
         if (wr_pos >= rscb_pkg::MAX_SPAN) wr_pos = 0;
         // The sum is 18 bits wide and wraps on its own.
         win_sum = win_sum + value;
         if (full) win_sum = win_sum - ring[wr_pos];
         ring[wr_pos] = value;
         if (wr_pos + 1 >= span) begin
            wr_pos = 0;
            full   = 1'b1;
         end else begin
            wr_pos++;
         end
         // The enable compares the count before its increment.
         if (seen == dist_reg) armed = 1'b1;
         if (seen != '1) seen++;
         rem = (mod_reg == 0) ? win_sum : win_sum % mod_reg;
         expected_boundary.push_back(armed && (rem == 0));
      endfunction

      function void check_result(logic actual);
         bit want;
         if (expected_boundary.size() == 0) begin
            errors++;
            $error("boundary: result with nothing expected, expected none, actual %0b",
                   actual);
            return;
         end
         want = expected_boundary.pop_front();
         if (actual !== logic'(want)) begin
            errors++;
            $error("boundary: expected %0b, actual %0b", want, actual);
         end
         if (actual === 1'b1) boundaries++;
      endfunction

      function int pending();
         return expected_boundary.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block inputs start at known values; reset starts high.
   // -------------------------------------------------------------------------
   logic                            clock;
   logic                            reset          = 1'b1;
   logic                            req_valid      = 1'b0;
   logic                            req_stall;
   logic                            req_opcode     = rscb_pkg::OP_DATA;
   logic [rscb_pkg::BYTE_W-1:0]     req_byte_value = '0;
   logic                            rsp_valid;
   logic                            rsp_stall      = 1'b0;
   logic                            rsp_boundary;
   logic                            csr_valid      = 1'b0;
   logic                            csr_ready;
   logic [rscb_pkg::CSR_IDX_W-1:0]  csr_index      = rscb_pkg::CSR_WINDOW_SPAN;
   logic [rscb_pkg::CSR_DATA_W-1:0] csr_data       = '0;

   chunk_scoreboard sb;

   // Idle percentages for the sender and the receiver, changed per stage.
   int send_idle_pct;
   int recv_idle_pct;
   int phases;

   rolling_sum_chunk_boundary dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_byte_value (req_byte_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_boundary   (rsp_boundary),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random, one decision per cycle.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Result monitor. Values are read at the edge, before any nonblocking
   // update of this time step, so the sampled handshake is the one that
   // the block sees.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_boundary);
      end
   end

   // Watchdog: abandon the run if no transaction of any kind is accepted
   // for too long.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Three idling stages: a slow receiver first, then a slow sender, then
   // both sides at full speed.
   task automatic set_idling(input int done_items);
      if (done_items < RANDOM_ITEMS / 3) begin
         send_idle_pct = 16;
         recv_idle_pct = 84;
      end else if (done_items < 2 * RANDOM_ITEMS / 3) begin
         send_idle_pct = 84;
         recv_idle_pct = 16;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // Offers one input transaction and returns at the edge that accepts it.
   // Valid is left high on return; the caller either offers the next
   // transaction or lowers it in the same time step.
   task automatic send_item(input logic op, input logic [rscb_pkg::BYTE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_byte_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(op, value);
   endtask

   // One register write. Valid stays high on return so that writes can
   // follow each other back to back.
   task automatic program_reg(input logic [rscb_pkg::CSR_IDX_W-1:0] idx,
                              input logic [rscb_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.apply_reg(idx, value);
   endtask

   // Waits until every expected result has come back and the block has
   // had time to finish any work in flight.
   task automatic drain();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers while the block is idle. A restart follows
   // when asked for, and always when the window is full and the new span
   // is wider: the ring would otherwise reach entries never written.
   task automatic start_phase(input logic [rscb_pkg::SPAN_W-1:0] span,
                              input logic [rscb_pkg::MOD_W-1:0]  modulus,
                              input logic [rscb_pkg::DIST_W-1:0] min_dist,
                              input bit                          force_restart);
      bit need_restart;
      drain();
      need_restart = force_restart ||
                     (sb.full && sb.eff_span(span) > sb.eff_span(sb.span_reg));
      // The bits above the span field are random; the block must drop them.
      program_reg(rscb_pkg::CSR_WINDOW_SPAN, {5'($urandom), span});
      program_reg(rscb_pkg::CSR_SUM_MODULUS, modulus);
      program_reg(rscb_pkg::CSR_MIN_DISTANCE, min_dist);
      csr_valid <= 1'b0;
      phases++;
      if (need_restart) send_item(rscb_pkg::OP_RESTART, 8'($urandom));
   endtask

   function automatic logic [rscb_pkg::BYTE_W-1:0] pick_byte(input int zero_pct);
      logic [rscb_pkg::BYTE_W-1:0] value;
      value = ($urandom_range(99) < zero_pct) ? '0 : 8'($urandom_range(255));
      return value;
   endfunction

   initial begin
      int                          rand_count;
      int                          phase_len;
      int                          zero_pct;
      logic [rscb_pkg::SPAN_W-1:0] span;
      logic [rscb_pkg::MOD_W-1:0]  modulus;
      logic [rscb_pkg::DIST_W-1:0] min_dist;

      sb         = new();
      rand_count = 0;
      phases     = 0;
      set_idling(0);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: a wide window and a distant enable, so no boundary.
      send_item(rscb_pkg::OP_DATA, 8'hFF);
      send_item(rscb_pkg::OP_DATA, 8'h00);

      // A span of zero acts as a single byte, and a zero modulus needs a
      // zero sum; with no minimum distance the first zero byte is a boundary.
      start_phase(11'd0, 16'd0, 16'd0, 1'b1);
      send_item(rscb_pkg::OP_DATA, 8'h00);
      send_item(rscb_pkg::OP_DATA, 8'hFF);
      send_item(rscb_pkg::OP_DATA, 8'h00);

      // The unused register index must leave every setting alone. Then a
      // span past the ring depth, the largest modulus and a short distance.
      drain();
      program_reg(CSR_UNUSED, 16'h0001);
      start_phase(11'd2047, 16'hFFFF, 16'd3, 1'b1);
      send_item(rscb_pkg::OP_DATA, 8'hFF);
      send_item(rscb_pkg::OP_DATA, 8'h00);
      send_item(rscb_pkg::OP_DATA, 8'h01);
      send_item(rscb_pkg::OP_DATA, 8'h80);

      // A short window that wraps, with restarts in the middle and twice in
      // a row.
      start_phase(11'd3, 16'd2, 16'd2, 1'b1);
      send_item(rscb_pkg::OP_DATA, 8'd1);
      send_item(rscb_pkg::OP_DATA, 8'd2);
      send_item(rscb_pkg::OP_DATA, 8'd3);
      send_item(rscb_pkg::OP_DATA, 8'd4);
      send_item(rscb_pkg::OP_DATA, 8'd5);
      send_item(rscb_pkg::OP_DATA, 8'd6);
      send_item(rscb_pkg::OP_RESTART, 8'hA5);
      send_item(rscb_pkg::OP_RESTART, 8'h5A);
      send_item(rscb_pkg::OP_DATA, 8'd7);
      send_item(rscb_pkg::OP_DATA, 8'd8);

      // The span shrinks while the window is not yet full, without a restart.
      start_phase(11'd2, 16'd2, 16'd2, 1'b0);
      send_item(rscb_pkg::OP_DATA, 8'd9);
      send_item(rscb_pkg::OP_DATA, 8'd10);

      // Random part: short phases with mostly small spans, moduli and
      // distances so that boundaries are frequent, and now and then the
      // extremes of each register.
      while (rand_count < RANDOM_ITEMS) begin
         case ($urandom_range(9))
            0:       span = 11'd0;
            1:       span = 11'd2047;
            2:       span = 11'($urandom_range(2047));
            default: span = 11'($urandom_range(1, 16));
         endcase
         case ($urandom_range(9))
            0:       modulus = 16'd0;
            1:       modulus = 16'hFFFF;
            2:       modulus = 16'($urandom);
            default: modulus = 16'($urandom_range(1, 8));
         endcase
         case ($urandom_range(9))
            0:       min_dist = 16'hFFFF;
            1:       min_dist = 16'($urandom);
            default: min_dist = 16'($urandom_range(0, 20));
         endcase
         // With a zero modulus only an all-zero window ends a chunk.
         zero_pct = (modulus == 0) ? 70 : 10;
         start_phase(span, modulus, min_dist, $urandom_range(1));
         phase_len = $urandom_range(20, 60);
         for (int i = 0; i < phase_len && rand_count < RANDOM_ITEMS; i++) begin
            if ($urandom_range(99) < 3) begin
               send_item(rscb_pkg::OP_RESTART, pick_byte(0));
            end else begin
               send_item(rscb_pkg::OP_DATA, pick_byte(zero_pct));
            end
            rand_count++;
            set_idling(rand_count);
         end
      end

      // A mid-sized window, run long enough to wrap past its last entry.
      start_phase(11'd64, 16'd3, 16'd0, 1'b1);
      repeat (LONG_RUN_ITEMS) send_item(rscb_pkg::OP_DATA, pick_byte(5));

      drain();
      $display("tb: %0d data bytes and %0d restarts over %0d register settings",
               sb.data_bytes, sb.restarts, phases);
      $display("tb: %0d chunk boundaries reported, %0d mismatches",
               sb.boundaries, sb.errors);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
